/* design/assert_macros.svh */
// Assertion macros used by the top level of the draw command batcher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* design/dcb_pkg.sv */
// Package with the types and constants of the draw command batcher.
package dcb_pkg;

  localparam int TEX_SLOTS     = 8;
  localparam int MAX_BATCHES   = 256;
  localparam int MAX_INSTANCES = 4096;

  localparam int SLOT_W = (TEX_SLOTS > 1) ? $clog2(TEX_SLOTS) : 1;
  localparam int SU_W   = $clog2(TEX_SLOTS + 1);
  localparam int BC_W   = $clog2(MAX_BATCHES + 1);
  localparam int IC_W   = $clog2(MAX_INSTANCES + 1);
  localparam int TEX_W  = 32;

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_DRAW  = 2'd1,
    OP_END   = 2'd2,
    OP_RSVD  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_DONE   = 2'd2
  } status_t;

  // Lookup request broadcast to every slot cell.
  typedef struct packed {
    logic [TEX_W-1:0]  id;
    logic [SU_W-1:0]   used;
    logic              wr;
    logic [SLOT_W-1:0] wr_slot;
  } probe_t;

  // Match information handed from one slot cell to the next.
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
  } match_t;

  typedef struct packed {
    status_t     status;
    logic        new_batch;
    logic [7:0]  batch_index;
    logic [11:0] instance_index;
    logic        has_texture;
    logic [2:0]  texture_slot;
    logic [8:0]  batch_total;
    logic [12:0] instance_total;
  } result_t;

endpackage

/* design/dcb_slot_cell.sv */
// One texture slot: holds a texture id and extends the first-match chain.
module dcb_slot_cell (
  input  logic                        clk,
  input  logic [dcb_pkg::SLOT_W-1:0]  idx,
  input  dcb_pkg::probe_t             probe,
  input  dcb_pkg::match_t             chain_in,
  output dcb_pkg::match_t             chain_out
);
  import dcb_pkg::*;

  logic [TEX_W-1:0] entry;
  logic             hit;

  // Only slots below the fill count are live; the earliest match wins.
  assign hit = (SU_W'(idx) < probe.used) && (entry == probe.id);

  always_comb begin
    chain_out = chain_in;
    if (!chain_in.found && hit) begin
      chain_out.found = 1'b1;
      chain_out.slot  = idx;
    end
  end

  always_ff @(posedge clk) begin
    if (probe.wr && (probe.wr_slot == idx)) begin
      entry <= probe.id;
    end
  end

endmodule

/* design/dcb_out_buf.sv */
// Result register with a skid stage so input and output stall independently.
module dcb_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  dcb_pkg::result_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output dcb_pkg::result_t out_data
);
  import dcb_pkg::*;

  logic    skid_valid;
  result_t skid_data;
  logic    drain;
  logic    take;

  assign in_ready = !skid_valid;
  assign drain    = out_valid && out_ready;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (!out_valid || drain) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (drain) begin
      out_valid  <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (!out_valid || drain) begin
        out_data <= in_data;
      end else begin
        skid_data <= in_data;
      end
    end else if (drain && skid_valid) begin
      out_data <= skid_data;
    end
  end

endmodule

/* design/draw_command_batcher.sv */
// Top level of the draw command batcher: packet state, slot cell row and result buffer.
// Each result is registered in the output register, or in the skid stage while it waits.
// Throughput: one request per cycle while the skid stage is empty, set by the combinational
// first-match pass through the row of slot cells with the batch and instance count update.
// Reset clears the counts, the fill count, the reject flag and the current clip and blend.
// The slot table itself is not cleared; only entries below the fill count are ever matched.
`include "assert_macros.svh"

module draw_command_batcher (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // clip_key [63:0], blend_mode [67:64], texture_id [99:68], zero fill [103:100]
  input  logic [103:0] s_tdata,
  // op [1:0], texture_valid [2]
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // new_batch [0], batch_index [8:1], instance_index [20:9], has_texture [21],
  // texture_slot [24:22], batch_total [33:25], instance_total [46:34], zero fill [47]
  output logic [47:0]  m_tdata,
  // status [1:0]
  output logic [1:0]   m_tuser
);
  import dcb_pkg::*;

  // Unpacked request fields.
  op_t              op;
  logic [63:0]      clip_key;
  logic [3:0]       blend_mode;
  logic             texture_valid;
  logic [TEX_W-1:0] texture_id;

  assign op            = op_t'(s_tuser[1:0]);
  assign texture_valid = s_tuser[2];
  assign clip_key      = s_tdata[63:0];
  assign blend_mode    = s_tdata[67:64];
  assign texture_id    = s_tdata[99:68];

  // Packet state.
  logic [63:0]     current_clip;
  logic [3:0]      current_blend;
  logic [SU_W-1:0] slots_used;
  logic [BC_W-1:0] batch_count;
  logic [IC_W-1:0] instance_count;
  logic            packet_rejected;

  logic [SU_W-1:0] slots_used_next;
  logic [BC_W-1:0] batch_count_next;

  logic    accept;
  logic    buf_ready;
  result_t res;
  result_t out_res;

  // Slot cell row. Cell zero sees an empty chain; the last cell's output is the lookup.
  probe_t probe;
  match_t chain [TEX_SLOTS+1];

  assign chain[0] = '0;

  for (genvar i = 0; i < TEX_SLOTS; i++) begin : g_cell
    dcb_slot_cell u_cell (
      .clk       (clk),
      .idx       (SLOT_W'(i)),
      .probe     (probe),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1])
    );
  end

  // Command decision. A batch opens when there is none yet or clip or blend changed.
  // A texture that misses a full table opens one more batch with the same clip and blend.
  // Both cannot happen for the same command, so the batch count grows by at most one.
  logic              is_cmd;
  logic              open_batch;
  logic              found;
  logic              need_slot;
  logic              overflow;
  logic              grow;
  logic              reject_cmd;
  logic              take_cmd;
  logic [SLOT_W-1:0] slot;

  assign is_cmd     = (op == OP_DRAW) && !packet_rejected;
  assign open_batch = (batch_count == '0) || (clip_key != current_clip) ||
                      (blend_mode != current_blend);
  assign found      = texture_valid && !open_batch && chain[TEX_SLOTS].found;
  assign need_slot  = texture_valid && !found;
  assign overflow   = need_slot && !open_batch && (slots_used >= SU_W'(TEX_SLOTS));
  assign grow       = open_batch || overflow;
  assign reject_cmd = is_cmd && ((grow && (batch_count >= BC_W'(MAX_BATCHES))) ||
                                 (instance_count >= IC_W'(MAX_INSTANCES)));
  assign take_cmd   = is_cmd && !reject_cmd;

  always_comb begin
    if (found) begin
      slot = chain[TEX_SLOTS].slot;
    end else if (grow) begin
      slot = '0;
    end else begin
      slot = SLOT_W'(slots_used);
    end
  end

  always_comb begin
    batch_count_next = batch_count + BC_W'(grow);
    if (need_slot) begin
      slots_used_next = grow ? SU_W'(1) : slots_used + SU_W'(1);
    end else begin
      slots_used_next = open_batch ? '0 : slots_used;
    end
  end

  assign probe = '{id:      texture_id,
                   used:    slots_used,
                   wr:      accept && take_cmd && need_slot,
                   wr_slot: slot};

  // Result assembly. Totals after a taken command are the updated counts.
  always_comb begin
    res                = '0;
    res.batch_total    = 9'(batch_count);
    res.instance_total = 13'(instance_count);
    unique case (op)
      OP_BEGIN: begin
        res.status         = ST_OK;
        res.batch_total    = '0;
        res.instance_total = '0;
      end
      OP_END: begin
        res.status = packet_rejected ? ST_REJECT : ST_DONE;
      end
      OP_RSVD: begin
        res.status = ST_OK;
      end
      OP_DRAW: begin
        if (take_cmd) begin
          res.status         = ST_OK;
          res.new_batch      = grow;
          res.batch_index    = 8'(batch_count_next - BC_W'(1));
          res.instance_index = 12'(instance_count);
          res.has_texture    = texture_valid;
          res.texture_slot   = texture_valid ? 3'(slot) : 3'd0;
          res.batch_total    = 9'(batch_count_next);
          res.instance_total = 13'(instance_count + IC_W'(1));
        end else begin
          res.status = ST_REJECT;
        end
      end
      default: begin
        res.status = ST_OK;
      end
    endcase
  end

  assign accept   = s_tvalid && s_tready;
  assign s_tready = buf_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      current_clip    <= '0;
      current_blend   <= '0;
      slots_used      <= '0;
      batch_count     <= '0;
      instance_count  <= '0;
      packet_rejected <= 1'b0;
    end else if (accept) begin
      if (op == OP_BEGIN) begin
        slots_used      <= '0;
        batch_count     <= '0;
        instance_count  <= '0;
        packet_rejected <= 1'b0;
      end else if (take_cmd) begin
        current_clip   <= clip_key;
        current_blend  <= blend_mode;
        slots_used     <= slots_used_next;
        batch_count    <= batch_count_next;
        instance_count <= instance_count + IC_W'(1);
      end else if (reject_cmd) begin
        packet_rejected <= 1'b1;
      end
    end
  end

  // Output register plus skid stage; a single waiting result does not stop new requests.
  dcb_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (buf_ready),
    .in_data   (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tuser = out_res.status;
  assign m_tdata = {1'b0, out_res.instance_total, out_res.batch_total, out_res.texture_slot,
                    out_res.has_texture, out_res.instance_index, out_res.batch_index,
                    out_res.new_batch};

  // The batch count never passes its capacity, and the fill count never passes the table.
  `ASSERT_NEVER(a_batch_cap, batch_count > BC_W'(MAX_BATCHES), "batch count over capacity")
  `ASSERT_NEVER(a_slot_cap, slots_used > SU_W'(TEX_SLOTS), "slot fill count over table size")
  // Slots can only be in use while a batch is open in the packet.
  `ASSERT_NEVER(a_slots_need_batch, (slots_used != '0) && (batch_count == '0),
                "slots in use with no batch")
  // Input only stalls when both the output register and the skid stage hold results.
  `ASSERT_PROP(a_stall_full, !s_tready |-> m_tvalid, "input stalled with empty output")

endmodule
